// ===== rtl/iv3a_pkg.sv =====
// ----------------------------------------------------------------------------
// iv3a_pkg
// Shared types and constants of the integer vector3 alu.
// ----------------------------------------------------------------------------
`default_nettype none

package iv3a_pkg;

    localparam int IV3A_WORD_W      = 32;
    localparam int IV3A_QUEUE_DEPTH = 2;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_NEG   = 4'd4;
    localparam logic [3:0] OP_MIN   = 4'd5;
    localparam logic [3:0] OP_MAX   = 4'd6;
    localparam logic [3:0] OP_DOT   = 4'd7;
    localparam logic [3:0] OP_CROSS = 4'd8;
    localparam logic [3:0] OP_DSQ   = 4'd9;
    localparam logic [3:0] OP_SUM   = 4'd10;
    localparam logic [3:0] OP_EQ    = 4'd11;

    typedef logic [IV3A_WORD_W-1:0] t_word;

    // one-hot operation class, all zero for an opcode without meaning
    typedef struct packed {
        logic add;
        logic sub;
        logic mul;
        logic div;
        logic neg;
        logic vmin;
        logic vmax;
        logic dot;
        logic crs;
        logic dsq;
        logic sum;
        logic eq;
    } t_dec;

    typedef struct packed {
        t_dec  dec;
        t_word ax;
        t_word ay;
        t_word az;
        t_word bx;
        t_word by;
        t_word bz;
    } t_cmd;

    typedef struct packed {
        t_word rx;
        t_word ry;
        t_word rz;
        t_word scalar;
        logic  is_equal;
        logic  div_zero;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/iv3a_if.sv =====
// ----------------------------------------------------------------------------
// iv3a_if
// Valid/ready channels carrying operand and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface iv3a_in_if;
    logic              valid;
    logic              ready;
    logic [3:0]        opcode;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;

    modport source (output valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
    modport sink   (input valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface iv3a_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] scalar_out;
    logic               is_equal;
    logic               div_zero;

    modport source (output valid, r_x, r_y, r_z, scalar_out, is_equal, div_zero,
                    input ready);
    modport sink   (input valid, r_x, r_y, r_z, scalar_out, is_equal, div_zero,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/iv3a_front.sv =====
// ----------------------------------------------------------------------------
// iv3a_front
// Accepts operand items and decodes the opcode into an operation class.
// ----------------------------------------------------------------------------
`default_nettype none

module iv3a_front import iv3a_pkg::*; (
    iv3a_in_if.sink    i_in,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_dec w_dec;

    always_comb begin
        w_dec = '0;
        unique case (i_in.opcode)
            OP_ADD:   w_dec.add  = 1'b1;
            OP_SUB:   w_dec.sub  = 1'b1;
            OP_MUL:   w_dec.mul  = 1'b1;
            OP_DIV:   w_dec.div  = 1'b1;
            OP_NEG:   w_dec.neg  = 1'b1;
            OP_MIN:   w_dec.vmin = 1'b1;
            OP_MAX:   w_dec.vmax = 1'b1;
            OP_DOT:   w_dec.dot  = 1'b1;
            OP_CROSS: w_dec.crs  = 1'b1;
            OP_DSQ:   w_dec.dsq  = 1'b1;
            OP_SUM:   w_dec.sum  = 1'b1;
            OP_EQ:    w_dec.eq   = 1'b1;
            default:  w_dec      = '0;
        endcase
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        o_cmd.dec = w_dec;
        o_cmd.ax  = i_in.a_x;
        o_cmd.ay  = i_in.a_y;
        o_cmd.az  = i_in.a_z;
        o_cmd.bx  = i_in.b_x;
        o_cmd.by  = i_in.b_y;
        o_cmd.bz  = i_in.b_z;
    end

endmodule

`default_nettype wire

// ===== rtl/iv3a_queue.sv =====
// ----------------------------------------------------------------------------
// iv3a_queue
// Short command queue between the decode front and the execution back.
// ----------------------------------------------------------------------------
`default_nettype none

module iv3a_queue import iv3a_pkg::*; #(
    parameter int DEPTH = IV3A_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    assign n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/iv3a_back.sv =====
// ----------------------------------------------------------------------------
// iv3a_back
// Execution pipeline: operand select, multipliers, combine, pipelined
// restoring divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iv3a_back import iv3a_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_head_valid,
    input  t_cmd i_head,
    output logic o_pop,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_res o_out
);

    localparam int W     = IV3A_WORD_W;
    localparam int NSTEP = IV3A_WORD_W;

    typedef struct packed {
        logic                 valid;
        t_dec                 dec;
        logic [2:0][W-1:0]    a;
        logic [2:0][W-1:0]    b;
        logic [5:0][W-1:0]    ma;
        logic [5:0][W-1:0]    mb;
    } t_s0;

    typedef struct packed {
        logic                 valid;
        t_dec                 dec;
        logic [5:0][W-1:0]    p;
        logic [2:0][W-1:0]    sv;
        logic [W-1:0]         ssum;
        logic                 eq;
        logic [2:0][W-1:0]    mn;
        logic [2:0][W-1:0]    md;
        logic [2:0]           qneg;
        logic [2:0]           zero;
    } t_s1;

    typedef struct packed {
        logic                 valid;
        logic                 div;
        t_res                 res;
        logic [2:0][W:0]      rem;
        logic [2:0][W-1:0]    q;
        logic [2:0][W-1:0]    mn;
        logic [2:0][W-1:0]    md;
        logic [2:0]           qneg;
        logic [2:0]           zero;
    } t_stp;

    function automatic t_stp f_step(input t_stp s);
        t_stp        o;
        logic [W:0]  t;
        o = s;
        for (int i = 0; i < 3; i++) begin
            t = {s.rem[i][W-1:0], s.mn[i][W-1]};
            if (t >= {1'b0, s.md[i]}) begin
                o.rem[i] = t - {1'b0, s.md[i]};
                o.q[i]   = {s.q[i][W-2:0], 1'b1};
            end else begin
                o.rem[i] = t;
                o.q[i]   = {s.q[i][W-2:0], 1'b0};
            end
            o.mn[i] = {s.mn[i][W-2:0], 1'b0};
        end
        return o;
    endfunction

    logic          w_en;
    t_s0           r_s0;
    t_s0           n_s0;
    t_s1           r_s1;
    t_s1           n_s1;
    t_stp          r_st [NSTEP+1];
    t_stp          n_st0;
    t_res          n_out;
    logic          r_ov;
    t_res          r_out;
    logic [2:0][W-1:0] w_d;

    assign w_en        = !r_ov || i_out_ready;
    assign o_pop       = w_en && i_head_valid;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    // operand select
    always_comb begin
        n_s0.valid = o_pop;
        n_s0.dec   = i_head.dec;
        n_s0.a     = {i_head.az, i_head.ay, i_head.ax};
        n_s0.b     = {i_head.bz, i_head.by, i_head.bx};
        for (int i = 0; i < 3; i++) begin
            w_d[i] = n_s0.a[i] - n_s0.b[i];
        end
        n_s0.ma = '0;
        n_s0.mb = '0;
        if (i_head.dec.crs) begin
            n_s0.ma = {n_s0.a[1], n_s0.a[0], n_s0.a[2], n_s0.a[0], n_s0.a[2], n_s0.a[1]};
            n_s0.mb = {n_s0.b[0], n_s0.b[2], n_s0.b[1], n_s0.b[1], n_s0.b[0], n_s0.b[2]};
        end else if (i_head.dec.dsq) begin
            for (int i = 0; i < 3; i++) begin
                n_s0.ma[i] = w_d[i];
                n_s0.mb[i] = w_d[i];
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                n_s0.ma[i] = n_s0.a[i];
                n_s0.mb[i] = n_s0.b[i];
            end
        end
    end

    // multiply and simple ops
    always_comb begin
        n_s1.valid = r_s0.valid;
        n_s1.dec   = r_s0.dec;
        for (int i = 0; i < 6; i++) begin
            n_s1.p[i] = W'(r_s0.ma[i] * r_s0.mb[i]);
        end
        for (int i = 0; i < 3; i++) begin
            n_s1.sv[i] = '0;
            if (r_s0.dec.add) begin
                n_s1.sv[i] = r_s0.a[i] + r_s0.b[i];
            end else if (r_s0.dec.sub) begin
                n_s1.sv[i] = r_s0.a[i] - r_s0.b[i];
            end else if (r_s0.dec.neg) begin
                n_s1.sv[i] = '0 - r_s0.a[i];
            end else if (r_s0.dec.vmin) begin
                n_s1.sv[i] = ($signed(r_s0.b[i]) < $signed(r_s0.a[i])) ? r_s0.b[i]
                                                                        : r_s0.a[i];
            end else if (r_s0.dec.vmax) begin
                n_s1.sv[i] = ($signed(r_s0.a[i]) < $signed(r_s0.b[i])) ? r_s0.b[i]
                                                                        : r_s0.a[i];
            end
            n_s1.mn[i]   = r_s0.a[i][W-1] ? '0 - r_s0.a[i] : r_s0.a[i];
            n_s1.md[i]   = r_s0.b[i][W-1] ? '0 - r_s0.b[i] : r_s0.b[i];
            n_s1.qneg[i] = r_s0.a[i][W-1] ^ r_s0.b[i][W-1];
            n_s1.zero[i] = (r_s0.b[i] == '0);
        end
        n_s1.ssum = r_s0.dec.sum ? r_s0.a[0] + r_s0.a[1] + r_s0.a[2] : '0;
        n_s1.eq   = r_s0.dec.eq && (r_s0.a == r_s0.b);
    end

    // combine products
    always_comb begin
        n_st0.valid = r_s1.valid;
        n_st0.div   = r_s1.dec.div;
        n_st0.res   = '0;
        if (r_s1.dec.mul) begin
            n_st0.res.rx = r_s1.p[0];
            n_st0.res.ry = r_s1.p[1];
            n_st0.res.rz = r_s1.p[2];
        end else if (r_s1.dec.crs) begin
            n_st0.res.rx = r_s1.p[0] - r_s1.p[3];
            n_st0.res.ry = r_s1.p[1] - r_s1.p[4];
            n_st0.res.rz = r_s1.p[2] - r_s1.p[5];
        end else begin
            n_st0.res.rx = r_s1.sv[0];
            n_st0.res.ry = r_s1.sv[1];
            n_st0.res.rz = r_s1.sv[2];
        end
        if (r_s1.dec.dot || r_s1.dec.dsq) begin
            n_st0.res.scalar = r_s1.p[0] + r_s1.p[1] + r_s1.p[2];
        end else begin
            n_st0.res.scalar = r_s1.ssum;
        end
        n_st0.res.is_equal = r_s1.eq;
        n_st0.rem  = '0;
        n_st0.q    = '0;
        n_st0.mn   = r_s1.mn;
        n_st0.md   = r_s1.md;
        n_st0.qneg = r_s1.qneg;
        n_st0.zero = r_s1.zero;
    end

    // quotient sign fix and zero divisor
    always_comb begin
        t_stp s;
        logic [2:0][W-1:0] v;
        s     = r_st[NSTEP];
        n_out = s.res;
        for (int i = 0; i < 3; i++) begin
            if (s.zero[i]) begin
                v[i] = '1;
            end else if (s.qneg[i]) begin
                v[i] = '0 - s.q[i];
            end else begin
                v[i] = s.q[i];
            end
        end
        if (s.div) begin
            n_out.rx       = v[0];
            n_out.ry       = v[1];
            n_out.rz       = v[2];
            n_out.div_zero = |s.zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0     <= '0;
            r_s1     <= '0;
            r_st[0]  <= '0;
            r_ov     <= 1'b0;
            r_out    <= '0;
        end else if (w_en) begin
            r_s0    <= n_s0;
            r_s1    <= n_s1;
            r_st[0] <= n_st0;
            r_ov    <= r_st[NSTEP].valid;
            r_out   <= n_out;
        end
    end

    for (genvar k = 0; k < NSTEP; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k+1] <= '0;
            end else if (w_en) begin
                r_st[k+1] <= f_step(r_st[k]);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/int_vec3_alu.sv =====
// ----------------------------------------------------------------------------
// int_vec3_alu
// Three-component signed 32-bit vector alu with valid/ready channels.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result side does not stall, and returns one
// result per item, in order. Every operation runs through the same pipeline: the
// queue, operand select, multiply, combine, the 32-step pipelined divider that
// resolves one quotient bit per stage, and the output register. A short queue
// decouples opcode decode from execution, and when the result side stalls the
// whole execution pipeline holds. Arithmetic wraps modulo 2^32; a zero divisor
// component gives -1 and sets div_zero.
// ----------------------------------------------------------------------------
`default_nettype none

module int_vec3_alu import iv3a_pkg::*; #(
    parameter int QUEUE_DEPTH = IV3A_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iv3a_in_if.sink     i_in,
    iv3a_out_if.source  o_out
);

    logic w_push;
    t_cmd w_cmd;
    logic w_full;
    logic w_pop;
    logic w_head_valid;
    t_cmd w_head;
    t_res w_res;

    iv3a_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_cmd  (w_cmd)
    );

    iv3a_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_cmd   (w_head)
    );

    iv3a_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out        (w_res)
    );

    assign o_out.r_x        = w_res.rx;
    assign o_out.r_y        = w_res.ry;
    assign o_out.r_z        = w_res.rz;
    assign o_out.scalar_out = w_res.scalar;
    assign o_out.is_equal   = w_res.is_equal;
    assign o_out.div_zero   = w_res.div_zero;

endmodule

`default_nettype wire

// ===== rtl/iv3a_chk.sv =====
// ----------------------------------------------------------------------------
// iv3a_chk
// Port-level checks on the result channel of the vector alu.
// ----------------------------------------------------------------------------
`default_nettype none

module iv3a_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [31:0] i_r_x,
    input logic [31:0] i_r_y,
    input logic [31:0] i_r_z,
    input logic [31:0] i_scalar,
    input logic        i_is_equal,
    input logic        i_div_zero
);

    // a pending item stays until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result item dropped while stalled");

    a_eq_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_is_equal |-> i_r_x == 32'd0 && i_r_y == 32'd0 && i_r_z == 32'd0
            && i_scalar == 32'd0 && !i_div_zero)
        else $error("equality item carries other fields");

    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_div_zero |-> i_scalar == 32'd0
            && (i_r_x == 32'hFFFF_FFFF || i_r_y == 32'hFFFF_FFFF || i_r_z == 32'hFFFF_FFFF))
        else $error("zero divisor without all-ones quotient");

    a_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_scalar != 32'd0 |-> i_r_x == 32'd0 && i_r_y == 32'd0 && i_r_z == 32'd0)
        else $error("scalar and vector result both set");

endmodule

bind int_vec3_alu iv3a_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_out.valid),
    .i_ready    (o_out.ready),
    .i_r_x      (o_out.r_x),
    .i_r_y      (o_out.r_y),
    .i_r_z      (o_out.r_z),
    .i_scalar   (o_out.scalar_out),
    .i_is_equal (o_out.is_equal),
    .i_div_zero (o_out.div_zero)
);

`default_nettype wire

// ===== tb/tb_int_vec3_alu.sv =====
// ----------------------------------------------------------------------------
// tb_int_vec3_alu
// Self-checking testbench of the integer vector3 alu.
// ----------------------------------------------------------------------------
// Drives operand items through the input channel under several idle and stall
// patterns, predicts each result from the operands, and compares every result
// field by field, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_int_vec3_alu;
    import iv3a_pkg::*;

    localparam int LATENCY     = 40;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [3:0]  op;
        logic [31:0] a [3];
        logic [31:0] b [3];
    } t_operands;

    typedef struct {
        logic [31:0] r [3];
        logic [31:0] s;
        logic        eq;
        logic        dz;
    } t_alu_res;

    int err_cnt = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %h expected %h", what, got, exp);
        err_cnt++;
    endtask

    class alu_scoreboard;
        t_alu_res pending[$];

        static function logic [31:0] sdiv(input logic [31:0] n, input logic [31:0] d,
                                          inout logic zero);
            logic [31:0] mn, md, q;
            if (d == 0) begin
                zero = 1'b1;
                return 32'hffff_ffff;
            end
            mn = n[31] ? -n : n;
            md = d[31] ? -d : d;
            q  = mn / md;
            return (n[31] ^ d[31]) ? -q : q;
        endfunction

        function void note_operands(input t_operands t);
            t_alu_res e;
            logic [31:0] d [3];
            logic z;
            z = 1'b0;
            e.r = '{0, 0, 0};
            e.s = 0;
            e.eq = 1'b0;
            e.dz = 1'b0;
            case (t.op)
                OP_ADD: for (int i = 0; i < 3; i++) e.r[i] = t.a[i] + t.b[i];
                OP_SUB: for (int i = 0; i < 3; i++) e.r[i] = t.a[i] - t.b[i];
                OP_MUL: for (int i = 0; i < 3; i++) e.r[i] = t.a[i] * t.b[i];
                OP_DIV: begin
                    for (int i = 0; i < 3; i++) e.r[i] = sdiv(t.a[i], t.b[i], z);
                    e.dz = z;
                end
                OP_NEG: for (int i = 0; i < 3; i++) e.r[i] = -t.a[i];
                OP_MIN: for (int i = 0; i < 3; i++)
                    e.r[i] = ($signed(t.b[i]) < $signed(t.a[i])) ? t.b[i] : t.a[i];
                OP_MAX: for (int i = 0; i < 3; i++)
                    e.r[i] = ($signed(t.a[i]) < $signed(t.b[i])) ? t.b[i] : t.a[i];
                OP_DOT: e.s = t.a[0]*t.b[0] + t.a[1]*t.b[1] + t.a[2]*t.b[2];
                OP_CROSS: begin
                    e.r[0] = t.a[1]*t.b[2] - t.a[2]*t.b[1];
                    e.r[1] = t.a[2]*t.b[0] - t.a[0]*t.b[2];
                    e.r[2] = t.a[0]*t.b[1] - t.a[1]*t.b[0];
                end
                OP_DSQ: begin
                    for (int i = 0; i < 3; i++) d[i] = t.a[i] - t.b[i];
                    e.s = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
                end
                OP_SUM: e.s = t.a[0] + t.a[1] + t.a[2];
                OP_EQ:  e.eq = (t.a[0] == t.b[0]) && (t.a[1] == t.b[1]) && (t.a[2] == t.b[2]);
                default: ;
            endcase
            pending.push_back(e);
        endfunction

        task check_result(input t_alu_res g);
            t_alu_res e;
            if (pending.size() == 0) begin
                report("unexpected item", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (g.r[0] !== e.r[0]) report("r_x", g.r[0], e.r[0]);
            if (g.r[1] !== e.r[1]) report("r_y", g.r[1], e.r[1]);
            if (g.r[2] !== e.r[2]) report("r_z", g.r[2], e.r[2]);
            if (g.s !== e.s) report("scalar_out", g.s, e.s);
            if (g.eq !== e.eq) report("is_equal", g.eq, e.eq);
            if (g.dz !== e.dz) report("div_zero", g.dz, e.dz);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    iv3a_in_if  in_ch();
    iv3a_out_if out_ch();

    int_vec3_alu uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    alu_scoreboard sb = new();
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.opcode = '0;
        in_ch.a_x = '0; in_ch.a_y = '0; in_ch.a_z = '0;
        in_ch.b_x = '0; in_ch.b_y = '0; in_ch.b_z = '0;
        out_ch.ready = 1'b0;
    end

    // receiver side with random stalls
    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_alu_res g;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            g.r[0] = out_ch.r_x;
            g.r[1] = out_ch.r_y;
            g.r[2] = out_ch.r_z;
            g.s  = out_ch.scalar_out;
            g.eq = out_ch.is_equal;
            g.dz = out_ch.div_zero;
            sb.check_result(g);
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("tb_int_vec3_alu: done, errors");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: return $urandom_range(20) - 10;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(input t_operands t);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= t.op;
        in_ch.a_x <= t.a[0]; in_ch.a_y <= t.a[1]; in_ch.a_z <= t.a[2];
        in_ch.b_x <= t.b[0]; in_ch.b_y <= t.b[1]; in_ch.b_z <= t.b[2];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_operands(t);
    endtask

    task automatic send_directed(input logic [3:0] op, input logic [31:0] ax, input logic [31:0] ay,
                                 input logic [31:0] az, input logic [31:0] bx,
                                 input logic [31:0] by, input logic [31:0] bz);
        t_operands t;
        t.op = op;
        t.a = '{ax, ay, az};
        t.b = '{bx, by, bz};
        send_item(t);
    endtask

    task automatic send_random(input int n);
        t_operands t;
        logic [31:0] s;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(15) == 0) t.op = 4'($urandom_range(15));
            else t.op = 4'($urandom_range(11));
            for (int i = 0; i < 3; i++) begin
                t.a[i] = rand_word();
                t.b[i] = rand_word();
            end
            case ($urandom_range(9))
                0: t.b = t.a;
                1: begin
                    s = rand_word();
                    t.b = '{s, s, s};
                end
                2: t.b[$urandom_range(2)] = t.a[$urandom_range(2)];
                default: ;
            endcase
            send_item(t);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: every operation, extremes, zero divisor, min over minus one
        send_directed(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 1, 1, 32'hffff_ffff, 32'hffff_ffff);
        send_directed(OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 0, 1, 32'hffff_ffff, 32'h8000_0000);
        send_directed(OP_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                      32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_directed(OP_DIV, 32'h8000_0000, 7, -7, 32'hffff_ffff, 2, 2);
        send_directed(OP_DIV, 5, -5, 32'h7fff_ffff, 0, 3, 0);
        send_directed(OP_DIV, 0, 32'h8000_0000, 32'h8000_0000, 0, 0, 32'h8000_0000);
        send_directed(OP_NEG, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0);
        send_directed(OP_MIN, 32'h8000_0000, 32'h7fff_ffff, -1, 32'h7fff_ffff, 32'h8000_0000, 1);
        send_directed(OP_MAX, 32'h8000_0000, 32'h7fff_ffff, -1, 32'h7fff_ffff, 32'h8000_0000, 1);
        send_directed(OP_DOT, 32'h7fff_ffff, 32'h8000_0000, 3, 32'h7fff_ffff, 32'h8000_0000, 4);
        send_directed(OP_CROSS, 1, 2, 3, 4, 5, 6);
        send_directed(OP_CROSS, 32'h8000_0000, 32'h7fff_ffff, -1,
                      32'h7fff_ffff, -1, 32'h8000_0000);
        send_directed(OP_DSQ, 32'h7fff_ffff, 0, 5, 32'h8000_0000, 0, 2);
        send_directed(OP_SUM, 32'h7fff_ffff, 1, 32'h8000_0000, 9, 9, 9);
        send_directed(OP_EQ, 5, -6, 32'h8000_0000, 5, -6, 32'h8000_0000);
        send_directed(OP_EQ, 5, -6, 32'h8000_0000, 5, -6, 32'h7fff_ffff);
        send_directed(4'd12, 1, 2, 3, 4, 5, 6);
        send_directed(4'd15, -1, -1, -1, -1, -1, -1);
        send_directed(OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                      32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        drain();

        send_random(160);
        idle_pct = 62;
        send_random(160);
        drain();
        idle_pct = 0; stall_pct = 62;
        send_random(160);
        idle_pct = 8; stall_pct = 8;
        send_random(160);
        drain();

        repeat (LATENCY) @(posedge i_clk);
        if (err_cnt == 0 && sb.pending.size() == 0) begin
            $display("tb_int_vec3_alu: done, clean");
        end else begin
            if (sb.pending.size() != 0) report("items missing", sb.pending.size(), 0);
            $display("tb_int_vec3_alu: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
